[design/tlv_pkg.sv]
// ---------------------------------------------------------------------------
// tlv_pkg
// Shared types, constants and the arc-tangent step table for the tank level
// and volume unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tlv_pkg;

   localparam int DATA_W   = 64;
   localparam int CNT_W    = 7;
   localparam int CORDIC_W = 40;
   localparam int ANGLE_W  = 32;

   localparam logic [7:0]  SAMPLES_PER_READ = 8'd11;
   localparam logic [16:0] WEIGHT_MIN       = 17'd655;
   localparam logic [16:0] WEIGHT_ONE       = 17'd65536;
   localparam logic [31:0] PI_Q28           = 32'd843314857;
   localparam logic [4:0]  CORDIC_LAST      = 5'd27;

   localparam logic [DATA_W-1:0] MASK37 = 64'h0000_001F_FFFF_FFFF;
   localparam logic [DATA_W-1:0] MASK38 = 64'h0000_003F_FFFF_FFFF;

   localparam logic [DATA_W-1:0] ROUND_EMA = 64'd32768;
   localparam logic [DATA_W-1:0] FILL_SCALE = 64'd10000;
   localparam logic [DATA_W-1:0] ML_DIV_VERT = 64'd10;
   localparam logic [DATA_W-1:0] ML_RND_VERT = 64'd5;
   localparam logic [DATA_W-1:0] ML_DIV_CYL = 64'd4096000;
   localparam logic [DATA_W-1:0] ML_RND_CYL = 64'd2048000;
   localparam logic [DATA_W-1:0] GAL_SCALE = 64'd264172;
   localparam logic [DATA_W-1:0] GAL_DIV = 64'd1000000;
   localparam logic [DATA_W-1:0] GAL_RND = 64'd500000;

   // multiplier bit counts (width of the b operand) and the divider's quotient bit count
   localparam logic [CNT_W-1:0] NB_WEIGHT = 7'd17;
   localparam logic [CNT_W-1:0] NB_16     = 7'd16;
   localparam logic [CNT_W-1:0] NB_FILL   = 7'd14;
   localparam logic [CNT_W-1:0] NB_32     = 7'd32;
   localparam logic [CNT_W-1:0] NB_GAL    = 7'd19;
   localparam logic [CNT_W-1:0] NB_DIV    = 7'd64;

   // configuration register indexes
   localparam logic [3:0] REG_SPAN_LOW  = 4'd0;
   localparam logic [3:0] REG_SPAN_HIGH = 4'd1;
   localparam logic [3:0] REG_RANGE     = 4'd2;
   localparam logic [3:0] REG_HEIGHT    = 4'd3;
   localparam logic [3:0] REG_AREA      = 4'd4;
   localparam logic [3:0] REG_LENGTH    = 4'd5;
   localparam logic [3:0] REG_WEIGHT    = 4'd6;
   localparam logic [3:0] REG_SHAPE     = 4'd7;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [CNT_W-1:0]  nbits;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                start;
      logic [CORDIC_W-1:0] px;
      logic [CORDIC_W-1:0] py;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic [ANGLE_W-1:0] angle;
   } cordic_rsp_type;

   // arc-tangent of 2^-i in Q28 radians
   function automatic logic [ANGLE_W-1:0] atan_step(input logic [4:0] i);
      logic [ANGLE_W-1:0] r;
      case (i)
         5'd0: r = 32'd210828714;
         5'd1: r = 32'd124459457;
         5'd2: r = 32'd65760959;
         5'd3: r = 32'd33381290;
         5'd4: r = 32'd16755422;
         5'd5: r = 32'd8385879;
         5'd6: r = 32'd4193963;
         5'd7: r = 32'd2097109;
         5'd8: r = 32'd1048571;
         5'd9: r = 32'd524287;
         default: r = 32'd1 << (5'd28 - i);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[design/tank_level_volume_from_adc_unit.sv]
// ---------------------------------------------------------------------------
// tank_level_volume_from_adc_unit
// Smooths converter codes over a read burst, then derives level, fill and
// volume with shared bit-serial multiply, divide, square root and CORDIC.
//
//   port group | dir | transfer when
//   req_*      | in  | req_valid & req_ready
//   rsp_*      | out | rsp_valid & rsp_ready
//   csr_*      | in  | csr_write_enable
//
// a burst's first code, or any code while the average is negative, loads the average
// directly, a later code waits on the 17-bit weight multiply; the last code then runs
// up to four divides and the multiplies; a part-full cylinder adds sqrt and CORDIC
// one item in flight; req_ready is high only while the sequencer is idle
// a finished result waits in the output register while new codes are taken
// synchronous reset clears state, count, average and result valid, and presets the registers
// ---------------------------------------------------------------------------
`default_nettype none

module tank_level_volume_from_adc_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_adc_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_smoothed_code,
   output logic signed [15:0] rsp_last_code,
   output logic [15:0] rsp_level_mm,
   output logic [13:0] rsp_fill_hundredths,
   output logic [37:0] rsp_volume_ml,
   output logic [36:0] rsp_volume_milligallons,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_index,
   input  logic [19:0] csr_write_data
);
   import tlv_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_EMA    = 5'd1;
   localparam logic [4:0] S_SC     = 5'd2;
   localparam logic [4:0] S_LEV_M  = 5'd3;
   localparam logic [4:0] S_LEV_D  = 5'd4;
   localparam logic [4:0] S_FILL   = 5'd5;
   localparam logic [4:0] S_FILL_M = 5'd6;
   localparam logic [4:0] S_FILL_D = 5'd7;
   localparam logic [4:0] S_VOL    = 5'd8;
   localparam logic [4:0] S_VERT_M = 5'd9;
   localparam logic [4:0] S_CYL_P  = 5'd10;
   localparam logic [4:0] S_CYL_S  = 5'd11;
   localparam logic [4:0] S_CYL_C  = 5'd12;
   localparam logic [4:0] S_CYL_D2 = 5'd13;
   localparam logic [4:0] S_CYL_T  = 5'd14;
   localparam logic [4:0] S_CYL_O  = 5'd15;
   localparam logic [4:0] S_CYL_V  = 5'd16;
   localparam logic [4:0] S_ML_D   = 5'd17;
   localparam logic [4:0] S_GAL    = 5'd18;
   localparam logic [4:0] S_GAL_M  = 5'd19;
   localparam logic [4:0] S_GAL_D  = 5'd20;
   localparam logic [4:0] S_OUT    = 5'd21;

   logic [4:0]  state_ff, state_in;
   logic [31:0] avg_ff, avg_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic [15:0] last_ff, last_in, sc_ff, sc_in, lev_ff, lev_in;
   logic [13:0] fill_ff, fill_in;
   logic [63:0] ml_ff, ml_in, gal_ff, gal_in, t1_ff, t1_in;
   logic [31:0] sq_ff, sq_in, th_ff, th_in;
   logic [17:0] off_ff, off_in;

   logic [15:0] low_ff, low_in, high_ff, high_in, range_ff, range_in;
   logic [15:0] height_ff, height_in, len_ff, len_in;
   logic [19:0] area_ff, area_in;
   logic [16:0] weight_ff, weight_in;
   logic        shape_ff, shape_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_sc_ff, rsp_sc_in, rsp_last_ff, rsp_last_in, rsp_lev_ff, rsp_lev_in;
   logic [13:0] rsp_fill_ff, rsp_fill_in;
   logic [37:0] rsp_ml_ff, rsp_ml_in;
   logic [36:0] rsp_gal_ff, rsp_gal_in;

   mul_req_type    mul_req;
   mul_rsp_type    mul_rsp;
   div_req_type    div_req;
   div_rsp_type    div_rsp;
   sqrt_req_type   sqrt_req;
   sqrt_rsp_type   sqrt_rsp;
   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;

   logic [16:0] w_clamp;
   logic [31:0] code_q;
   logic [63:0] ema_d, ema_rnd;
   logic [32:0] sc_sum;
   logic [16:0] sc_hi, span_diff, span_mag, off_mag;
   logic        span_neg;
   logic [63:0] den64, lev_a, lev_num, lev_n2, t1_sh, o_sh, area_raw, area_pos;
   logic [17:0] off_calc;

   tlv_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   tlv_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   tlv_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));
   tlv_cordic u_cordic (.clock(clock), .reset(reset), .req(cordic_req), .rsp(cordic_rsp));

   always_comb begin
      w_clamp   = (weight_ff < WEIGHT_MIN) ? WEIGHT_MIN :
                  ((weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff);
      code_q    = {req_adc_code, 16'h0000};
      ema_d     = {{32{code_q[31]}}, code_q} - {{32{avg_ff[31]}}, avg_ff};
      ema_rnd   = mul_rsp.prod + ROUND_EMA;
      sc_sum    = {avg_ff[31], avg_ff} + 33'd32768;
      sc_hi     = sc_sum[32:16];
      span_diff = {high_ff[15], high_ff} - {low_ff[15], low_ff};
      span_neg  = span_diff[16];
      span_mag  = span_neg ? (~span_diff + 17'd1) : span_diff;
      den64     = {31'd0, span_mag, 16'h0000};
      lev_a     = {{32{avg_ff[31]}}, avg_ff} - {{32{low_ff[15]}}, low_ff, 16'h0000};
      lev_num   = span_neg ? (~mul_rsp.prod + 64'd1) : mul_rsp.prod;
      lev_n2    = {lev_num[62:0], 1'b0} + den64;
      off_calc  = {2'b00, height_ff} - {1'b0, lev_ff, 1'b0};
      off_mag   = off_ff[17] ? 17'(~off_ff + 18'd1) : off_ff[16:0];
      t1_sh     = {{18{t1_ff[63]}}, t1_ff[63:18]};
      o_sh      = {{5{mul_rsp.prod[63]}}, mul_rsp.prod[63:5]};
      area_raw  = t1_sh - o_sh;
      area_pos  = area_raw[63] ? 64'd0 : area_raw;
   end

   always_comb begin
      state_in  = state_ff;
      avg_in    = avg_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      last_in   = last_ff;
      sc_in     = sc_ff;
      lev_in    = lev_ff;
      fill_in   = fill_ff;
      ml_in     = ml_ff;
      gal_in    = gal_ff;
      t1_in     = t1_ff;
      sq_in     = sq_ff;
      th_in     = th_ff;
      off_in    = off_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      range_in  = range_ff;
      height_in = height_ff;
      area_in   = area_ff;
      len_in    = len_ff;
      weight_in = weight_ff;
      shape_in  = shape_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_sc_in    = rsp_sc_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_lev_in   = rsp_lev_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_ml_in    = rsp_ml_ff;
      rsp_gal_in   = rsp_gal_ff;

      mul_req    = '0;
      div_req    = '0;
      sqrt_req   = '0;
      cordic_req = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         case (csr_index)
            REG_SPAN_LOW:  low_in    = csr_write_data[15:0];
            REG_SPAN_HIGH: high_in   = csr_write_data[15:0];
            REG_RANGE:     range_in  = csr_write_data[15:0];
            REG_HEIGHT:    height_in = csr_write_data[15:0];
            REG_AREA:      area_in   = csr_write_data;
            REG_LENGTH:    len_in    = csr_write_data[15:0];
            REG_WEIGHT:    weight_in = csr_write_data[16:0];
            REG_SHAPE:     shape_in  = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in = req_adc_code;
               fin_in  = (cnt_ff == SAMPLES_PER_READ - 8'd1);
               cnt_in  = fin_in ? 8'd0 : cnt_ff + 8'd1;
               if (cnt_ff == 8'd0 || avg_ff[31]) begin
                  avg_in   = code_q;
                  state_in = fin_in ? S_SC : S_IDLE;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = ema_d;
                  mul_req.b     = {47'd0, w_clamp};
                  mul_req.nbits = NB_WEIGHT;
                  state_in      = S_EMA;
               end
            end
         end
         S_EMA: begin
            if (mul_rsp.done) begin
               avg_in   = avg_ff + ema_rnd[47:16];
               state_in = fin_ff ? S_SC : S_IDLE;
            end
         end
         S_SC: begin
            sc_in = (!sc_hi[16] && sc_hi[15]) ? 16'h7FFF : sc_hi[15:0];
            if (low_ff == high_ff) begin
               lev_in   = '0;
               state_in = S_FILL;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = lev_a;
               mul_req.b     = {48'd0, range_ff};
               mul_req.nbits = NB_16;
               state_in      = S_LEV_M;
            end
         end
         S_LEV_M: begin
            if (mul_rsp.done) begin
               if (lev_n2[63]) begin
                  lev_in   = '0;
                  state_in = S_FILL;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = lev_n2;
                  div_req.den   = {den64[62:0], 1'b0};
                  state_in      = S_LEV_D;
               end
            end
         end
         S_LEV_D: begin
            if (div_rsp.done) begin
               lev_in   = (div_rsp.quot > {48'd0, height_ff}) ? height_ff : div_rsp.quot[15:0];
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (height_ff == 16'd0) begin
               fill_in  = '0;
               state_in = S_VOL;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = {48'd0, lev_ff};
               mul_req.b     = FILL_SCALE;
               mul_req.nbits = NB_FILL;
               state_in      = S_FILL_M;
            end
         end
         S_FILL_M: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.prod + {49'd0, height_ff[15:1]};
               div_req.den   = {48'd0, height_ff};
               state_in      = S_FILL_D;
            end
         end
         S_FILL_D: begin
            if (div_rsp.done) begin
               fill_in  = div_rsp.quot[13:0];
               state_in = S_VOL;
            end
         end
         S_VOL: begin
            if (!shape_ff) begin
               mul_req.start = 1'b1;
               mul_req.a     = {44'd0, area_ff};
               mul_req.b     = {48'd0, lev_ff};
               mul_req.nbits = NB_16;
               state_in      = S_VERT_M;
            end else if (lev_ff == 16'd0) begin
               ml_in    = '0;
               state_in = S_GAL;
            end else if (lev_ff >= height_ff) begin
               th_in         = PI_Q28;
               off_in        = '0;
               sq_in         = '0;
               mul_req.start = 1'b1;
               mul_req.a     = {48'd0, height_ff};
               mul_req.b     = {48'd0, height_ff};
               mul_req.nbits = NB_16;
               state_in      = S_CYL_D2;
            end else begin
               off_in        = off_calc;
               mul_req.start = 1'b1;
               mul_req.a     = {48'd0, lev_ff};
               mul_req.b     = {48'd0, height_ff - lev_ff};
               mul_req.nbits = NB_16;
               state_in      = S_CYL_P;
            end
         end
         S_VERT_M: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.prod + ML_RND_VERT;
               div_req.den   = ML_DIV_VERT;
               state_in      = S_ML_D;
            end
         end
         S_CYL_P: begin
            if (mul_rsp.done) begin
               sqrt_req.start    = 1'b1;
               sqrt_req.radicand = {mul_rsp.prod[31:0], 32'd0};
               state_in          = S_CYL_S;
            end
         end
         S_CYL_S: begin
            if (sqrt_rsp.done) begin
               sq_in            = sqrt_rsp.root;
               cordic_req.start = 1'b1;
               cordic_req.px    = {7'd0, off_mag, 16'h0000};
               cordic_req.py    = {7'd0, sqrt_rsp.root, 1'b0};
               state_in         = S_CYL_C;
            end
         end
         S_CYL_C: begin
            if (cordic_rsp.done) begin
               th_in         = off_ff[17] ? (PI_Q28 - cordic_rsp.angle) : cordic_rsp.angle;
               mul_req.start = 1'b1;
               mul_req.a     = {48'd0, height_ff};
               mul_req.b     = {48'd0, height_ff};
               mul_req.nbits = NB_16;
               state_in      = S_CYL_D2;
            end
         end
         S_CYL_D2: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = {{32{th_ff[31]}}, th_ff};
               mul_req.b     = mul_rsp.prod;
               mul_req.nbits = NB_32;
               state_in      = S_CYL_T;
            end
         end
         S_CYL_T: begin
            if (mul_rsp.done) begin
               t1_in         = mul_rsp.prod;
               mul_req.start = 1'b1;
               mul_req.a     = {{46{off_ff[17]}}, off_ff};
               mul_req.b     = {32'd0, sq_ff};
               mul_req.nbits = NB_32;
               state_in      = S_CYL_O;
            end
         end
         S_CYL_O: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = area_pos;
               mul_req.b     = {48'd0, len_ff};
               mul_req.nbits = NB_16;
               state_in      = S_CYL_V;
            end
         end
         S_CYL_V: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.prod + ML_RND_CYL;
               div_req.den   = ML_DIV_CYL;
               state_in      = S_ML_D;
            end
         end
         S_ML_D: begin
            if (div_rsp.done) begin
               ml_in    = div_rsp.quot;
               state_in = S_GAL;
            end
         end
         S_GAL: begin
            mul_req.start = 1'b1;
            mul_req.a     = ml_ff;
            mul_req.b     = GAL_SCALE;
            mul_req.nbits = NB_GAL;
            state_in      = S_GAL_M;
         end
         S_GAL_M: begin
            if (mul_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = mul_rsp.prod + GAL_RND;
               div_req.den   = GAL_DIV;
               state_in      = S_GAL_D;
            end
         end
         S_GAL_D: begin
            if (div_rsp.done) begin
               gal_in   = div_rsp.quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sc_in    = sc_ff;
               rsp_last_in  = last_ff;
               rsp_lev_in   = lev_ff;
               rsp_fill_in  = fill_ff;
               rsp_ml_in    = (ml_ff > MASK38) ? MASK38[37:0] : ml_ff[37:0];
               rsp_gal_in   = (gal_ff > MASK37) ? MASK37[36:0] : gal_ff[36:0];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         avg_ff       <= '0;
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         last_ff      <= '0;
         low_ff       <= 16'd0;
         high_ff      <= 16'd32767;
         range_ff     <= 16'd5000;
         height_ff    <= 16'd2000;
         area_ff      <= 20'd10000;
         len_ff       <= 16'd2000;
         weight_ff    <= 17'd19661;
         shape_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         last_ff      <= last_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         range_ff     <= range_in;
         height_ff    <= height_in;
         area_ff      <= area_in;
         len_ff       <= len_in;
         weight_ff    <= weight_in;
         shape_ff     <= shape_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sc_ff       <= sc_in;
      lev_ff      <= lev_in;
      fill_ff     <= fill_in;
      ml_ff       <= ml_in;
      gal_ff      <= gal_in;
      t1_ff       <= t1_in;
      sq_ff       <= sq_in;
      th_ff       <= th_in;
      off_ff      <= off_in;
      rsp_sc_ff   <= rsp_sc_in;
      rsp_last_ff <= rsp_last_in;
      rsp_lev_ff  <= rsp_lev_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_ml_ff   <= rsp_ml_in;
      rsp_gal_ff  <= rsp_gal_in;
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_smoothed_code       = rsp_sc_ff;
   assign rsp_last_code           = rsp_last_ff;
   assign rsp_level_mm            = rsp_lev_ff;
   assign rsp_fill_hundredths     = rsp_fill_ff;
   assign rsp_volume_ml           = rsp_ml_ff;
   assign rsp_volume_milligallons = rsp_gal_ff;

endmodule

`default_nettype wire

[design/tlv_mul.sv]
// ---------------------------------------------------------------------------
// tlv_mul
// Bit-serial shift-add multiplier, one bit of b per cycle, product mod 2^64.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  tlv_pkg::mul_req_type req,
   output tlv_pkg::mul_rsp_type rsp
);
   import tlv_pkg::*;

   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         cnt_in  = req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[DATA_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[DATA_W-1:1]};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

`default_nettype wire

[design/tlv_div.sv]
// ---------------------------------------------------------------------------
// tlv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tlv_pkg::div_req_type req,
   output tlv_pkg::div_rsp_type rsp
);
   import tlv_pkg::*;

   logic [DATA_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = NB_DIV;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W+1]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

`default_nettype wire

[design/tlv_sqrt.sv]
// ---------------------------------------------------------------------------
// tlv_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  tlv_pkg::sqrt_req_type req,
   output tlv_pkg::sqrt_rsp_type rsp
);
   import tlv_pkg::*;

   logic [DATA_W-1:0] n_ff, n_in;
   logic [33:0]       rem_ff, rem_in;
   logic [31:0]       root_ff, root_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [35:0]       cur, trial, diff;

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cur     = {rem_ff, n_ff[DATA_W-1:DATA_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = cur - trial;
      if (req.start) begin
         n_in    = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[DATA_W-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = diff[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = cur[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

`default_nettype wire

[design/tlv_cordic.sv]
// ---------------------------------------------------------------------------
// tlv_cordic
// Vectoring CORDIC, one rotation per cycle, angle of (px, py) in Q28.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  tlv_pkg::cordic_req_type req,
   output tlv_pkg::cordic_rsp_type rsp
);
   import tlv_pkg::*;

   logic signed [CORDIC_W-1:0] px_ff, px_in, py_ff, py_in, dx, dy;
   logic [ANGLE_W-1:0]         z_ff, z_in, step;
   logic [4:0]                 i_ff, i_in;
   logic                       busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dx      = py_ff >>> i_ff;
      dy      = px_ff >>> i_ff;
      step    = atan_step(i_ff);
      if (req.start) begin
         px_in   = $signed(req.px);
         py_in   = $signed(req.py);
         z_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!py_ff[CORDIC_W-1]) begin
            px_in = px_ff + dx;
            py_in = py_ff - dy;
            z_in  = z_ff + step;
         end else begin
            px_in = px_ff - dx;
            py_in = py_ff + dy;
            z_in  = z_ff - step;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == CORDIC_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
      z_ff  <= z_in;
      i_ff  <= i_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.angle = z_ff;

endmodule

`default_nettype wire

[design/tlv_checker.sv]
// ---------------------------------------------------------------------------
// tlv_checker
// Port-level checks on the tank level unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_smoothed_code,
   input logic [15:0] rsp_level_mm,
   input logic [13:0] rsp_fill_hundredths,
   input logic [37:0] rsp_volume_ml,
   input logic [36:0] rsp_volume_milligallons
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level_mm)
         && $stable(rsp_volume_ml) && $stable(rsp_smoothed_code))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_hundredths <= 14'd10000)
      else $error("fill above full");

   // empty tank gives no fill and no volume
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_mm == 16'd0 |-> rsp_fill_hundredths == 14'd0
         && rsp_volume_ml == 38'd0 && rsp_volume_milligallons == 37'd0)
      else $error("volume at zero level");

endmodule

bind tank_level_volume_from_adc_unit tlv_checker u_tlv_checker (.*);

`default_nettype wire

[test/testbench.sv]
// ---------------------------------------------------------------------------
// tank level and volume testbench
// Sends signed converter codes in read bursts under many register settings
// and checks every level, fill and volume reading against an in-bench
// predictor. Each side's idling is varied over three phases.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tlv_pkg::*;

   localparam logic [3:0] REG_UNUSED_FIRST = 4'd8;
   localparam int SETTLE_CYCLES = 700;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam int ITEM_TARGET = 1600;

   typedef struct {
      logic signed [15:0] smoothed;
      logic signed [15:0] last;
      logic [15:0]        level;
      logic [13:0]        fill;
      logic [37:0]        ml;
      logic [36:0]        mgal;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_adc_code = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_smoothed_code;
   logic signed [15:0] rsp_last_code;
   logic [15:0] rsp_level_mm;
   logic [13:0] rsp_fill_hundredths;
   logic [37:0] rsp_volume_ml;
   logic [36:0] rsp_volume_milligallons;
   logic csr_write_enable = 1'b0;
   logic [3:0] csr_index = '0;
   logic [19:0] csr_write_data = '0;

   // predictor state and register copy
   logic [31:0] avg_q16;
   int          burst_pos;
   logic [15:0] span_low, span_high, range_mm, height_mm, length_mm;
   logic [19:0] area_cm2;
   logic [16:0] weight;
   logic        shape;

   reading_type expected_readings[$];
   int  errors = 0;
   int  items_sent = 0;
   int  readings_checked = 0;
   int  settings_used = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   longint cycles = 0;

   tank_level_volume_from_adc_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tank_level_volume_from_adc_unit: mismatch");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic longint fdiv(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint arc_angle(longint px, longint py);
      longint z = 0;
      longint stp, dx, dy;
      for (int i = 0; i < 28; i++) begin
         stp = longint'(atan_step(5'(i)));
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx; py -= dy; z += stp;
         end else begin
            px -= dx; py += dy; z -= stp;
         end
      end
      return z;
   endfunction

   function automatic longint cylinder_volume(longint lev);
      longint dia = longint'(height_mm);
      longint pi_q28 = longint'(PI_Q28);
      longint area, s, off, mag, th;
      if (lev <= 0) return 0;
      if (lev >= dia) area = (dia * dia * pi_q28) >>> 18;
      else begin
         s = longint'(root64(longint'(lev * (dia - lev)) << 32));
         off = dia - 2 * lev;
         mag = off < 0 ? -off : off;
         th = arc_angle(mag * 65536, 2 * s);
         if (off < 0) th = pi_q28 - th;
         area = ((dia * dia * th) >>> 18) - ((off * s) >>> 5);
         if (area < 0) area = 0;
      end
      return (area * longint'(length_mm) + 2048000) / 4096000;
   endfunction

   function automatic void predict_reading(logic signed [15:0] code);
      longint c = longint'(code);
      longint a = longint'(signed'(avg_q16));
      longint w, sc, lev, lo, hi, num, den, fill, ml, mgal;
      reading_type r;
      if (burst_pos == 0 || a < 0) a = c * 65536;
      else begin
         w = longint'(weight);
         if (w < 655) w = 655;
         if (w > 65536) w = 65536;
         a = (a * (65536 - w) + c * 65536 * w + 32768) >>> 16;
      end
      avg_q16 = a[31:0];
      burst_pos++;
      if (burst_pos < int'(SAMPLES_PER_READ)) return;
      burst_pos = 0;
      sc = fdiv(a + 32768, 65536);
      if (sc > 32767) sc = 32767;
      lo = longint'(signed'(span_low));
      hi = longint'(signed'(span_high));
      if (lo == hi) lev = 0;
      else begin
         num = (a - lo * 65536) * longint'(range_mm);
         den = (hi - lo) * 65536;
         if (den < 0) begin
            num = -num; den = -den;
         end
         lev = fdiv(2 * num + den, 2 * den);
      end
      if (lev < 0) lev = 0;
      if (lev > longint'(height_mm)) lev = longint'(height_mm);
      fill = (height_mm != 0) ?
         (lev * 10000 + longint'(height_mm) / 2) / longint'(height_mm) : 0;
      ml = shape ? cylinder_volume(lev) : (longint'(area_cm2) * lev + 5) / 10;
      mgal = (ml * 264172 + 500000) / 1000000;
      if (mgal > longint'(MASK37)) mgal = longint'(MASK37);
      if (ml > longint'(MASK38)) ml = longint'(MASK38);
      r.smoothed = sc[15:0];
      r.last = code;
      r.level = lev[15:0];
      r.fill = fill[13:0];
      r.ml = ml[37:0];
      r.mgal = mgal[36:0];
      expected_readings.push_back(r);
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) report("unexpected transfer", 1, 0);
         else begin
            e = expected_readings.pop_front();
            readings_checked++;
            if (rsp_smoothed_code !== e.smoothed)
               report("smoothed_code", rsp_smoothed_code, e.smoothed);
            if (rsp_last_code !== e.last) report("last_code", rsp_last_code, e.last);
            if (rsp_level_mm !== e.level) report("level_mm", rsp_level_mm, e.level);
            if (rsp_fill_hundredths !== e.fill)
               report("fill_hundredths", rsp_fill_hundredths, e.fill);
            if (rsp_volume_ml !== e.ml) report("volume_ml", rsp_volume_ml, e.ml);
            if (rsp_volume_milligallons !== e.mgal)
               report("volume_milligallons", rsp_volume_milligallons, e.mgal);
         end
      end
   end

   // called just after a falling edge, returns just after one
   task automatic send_code(logic signed [15:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_adc_code <= code;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_reading(code);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(logic [3:0] idx, logic [19:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_SPAN_LOW:  span_low = data[15:0];
         REG_SPAN_HIGH: span_high = data[15:0];
         REG_RANGE:     range_mm = data[15:0];
         REG_HEIGHT:    height_mm = data[15:0];
         REG_AREA:      area_cm2 = data;
         REG_LENGTH:    length_mm = data[15:0];
         REG_WEIGHT:    weight = data[16:0];
         REG_SHAPE:     shape = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_tank(logic signed [15:0] lo, logic signed [15:0] hi,
                               logic [15:0] rng, logic [15:0] hgt, logic [19:0] area,
                               logic [15:0] len, logic [19:0] w, logic shp);
      settle();
      write_register(REG_SPAN_LOW, {4'($urandom_range(15)), lo});
      write_register(REG_SPAN_HIGH, {4'($urandom_range(15)), hi});
      write_register(REG_RANGE, {4'($urandom_range(15)), rng});
      write_register(REG_HEIGHT, {4'($urandom_range(15)), hgt});
      write_register(REG_AREA, area);
      write_register(REG_LENGTH, {4'($urandom_range(15)), len});
      write_register(REG_WEIGHT, w);
      write_register(REG_SHAPE, {19'($urandom_range(20'h7FFFF)), shp});
      write_register(REG_UNUSED_FIRST + 4'($urandom_range(7)), 20'($urandom));
      settings_used++;
   endtask

   function automatic logic signed [15:0] pick_code(int centre, int spread);
      int v;
      if ($urandom_range(9) == 0) return 16'($urandom);
      v = centre + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   function automatic logic [15:0] pick_wide();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_burst(int centre, int spread);
      repeat (int'(SAMPLES_PER_READ)) send_code(pick_code(centre, spread));
   endtask

   task automatic test_code_extremes();
      logic signed [15:0] pattern[11] = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1,
         16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh4000, 16'sh8000, 16'sd100, 16'sh7FFF};
      foreach (pattern[i]) send_code(pattern[i]);
      for (int i = 0; i < 11; i++) send_code(16'(32767 - i * 3000));
   endtask

   task automatic test_special_settings();
      // zero span
      program_tank(16'sd1000, 16'sd1000, 16'd5000, 16'd2000, 20'd10000, 16'd2000,
                   20'd19661, 1'b0);
      send_burst(1000, 200);
      // reversed span, weight below minimum, oversized area
      program_tank(16'sd30000, -16'sd30000, 16'd65535, 16'd65535, 20'hFFFFF,
                   16'd65535, 20'd0, 1'b0);
      send_burst(0, 30000);
      // zero height, weight above one
      program_tank(-16'sd32768, 16'sd32767, 16'd4000, 16'd0, 20'd5000, 16'd1000,
                   20'h1FFFF, 1'b1);
      send_burst(0, 20000);
      // empty cylinder
      program_tank(16'sd0, 16'sd32767, 16'd5000, 16'd2000, 20'd1, 16'd2000,
                   20'd65536, 1'b1);
      send_burst(-5000, 1000);
      // full cylinder, largest sizes
      program_tank(16'sd0, 16'sd100, 16'd65535, 16'd65535, 20'd0, 16'd65535,
                   20'd655, 1'b1);
      send_burst(30000, 2000);
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int quota);
      int goal = items_sent + quota;
      int lo, hi, centre;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (items_sent < goal) begin
         lo = $urandom_range(65535) - 32768;
         hi = ($urandom_range(7) == 0) ? lo : $urandom_range(65535) - 32768;
         program_tank(16'(lo), 16'(hi), pick_wide(),
                      ($urandom_range(3) == 0) ? pick_wide() : 16'($urandom_range(4000)),
                      ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom),
                      pick_wide(), 20'($urandom), 1'($urandom));
         repeat ($urandom_range(3, 7)) begin
            centre = (lo < hi) ? $urandom_range(hi - lo) + lo : $urandom_range(lo - hi) + hi;
            if ($urandom_range(7) == 0)
               repeat ($urandom_range(1, 10)) send_code(16'($urandom));
            else send_burst(centre, $urandom_range(3000));
         end
      end
   endtask

   initial begin
      avg_q16 = '0;
      burst_pos = 0;
      span_low = 16'd0;
      span_high = 16'd32767;
      range_mm = 16'd5000;
      height_mm = 16'd2000;
      area_cm2 = 20'd10000;
      length_mm = 16'd2000;
      weight = 17'd19661;
      shape = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_code_extremes();
      test_special_settings();
      test_random_phase(22, 53, ITEM_TARGET / 3);
      test_random_phase(53, 22, ITEM_TARGET / 3);
      test_random_phase(0, 0, ITEM_TARGET / 3);
      settle();
      $display("sent %0d codes under %0d register settings, checked %0d readings",
               items_sent, settings_used, readings_checked);
      $display("idling varied on both channels, %0d errors", errors);
      if (errors == 0) $display("tank_level_volume_from_adc_unit: match");
      else $display("tank_level_volume_from_adc_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
design/tlv_pkg.sv
design/tlv_mul.sv
design/tlv_div.sv
design/tlv_sqrt.sv
design/tlv_cordic.sv
design/tank_level_volume_from_adc_unit.sv
design/tlv_checker.sv
test/testbench.sv
